// ===== sv/hcpt_pkg.sv =====
package hcpt_pkg;

   localparam int SENSOR_W   = 3;
   localparam int STATE_W    = 3;
   localparam int INDEX_W    = 3;
   localparam int GATE_W     = 6;
   localparam int POSITION_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_STATE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_LEAD = 1'd1;

   localparam logic [STATE_W-1:0] HOME_STATE_RESET = 3'd0;
   localparam logic [STATE_W-1:0] PHASE_LEAD_RESET = 3'd2;
   localparam logic [STATE_W-1:0] STATE_INVALID    = 3'd7;

   // High-side gate lines are active-low; this mask inverts them.
   localparam logic [GATE_W-1:0] HIGH_SIDE_MASK = 6'h2A;

   // Six-step gate patterns selected by the drive index.
   localparam logic [GATE_W-1:0] GATE_PATTERN [8] = '{
      6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
   };

   // Sensor code to rotor state; codes 000 and 111 are invalid.
   localparam logic [STATE_W-1:0] SENSOR_TO_STATE [8] = '{
      3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
   };

   typedef struct packed {
      logic [STATE_W-1:0] rotor_state;
      logic [INDEX_W-1:0] drive_index;
      logic [GATE_W-1:0]  gate_lines;
   } hcpt_decode_type;

   // Truncating remainder by six of a value in -5..16. Negative values
   // already lie within -5..-1 and are their own remainder.
   function automatic logic signed [5:0] rem6(input logic signed [5:0] sum);
      logic signed [5:0] r;
      if (sum < 0) begin
         r = sum;
      end else if (sum >= 6'sd12) begin
         r = sum - 6'sd12;
      end else if (sum >= 6'sd6) begin
         r = sum - 6'sd6;
      end else begin
         r = sum;
      end
      return r;
   endfunction

endpackage

// ===== sv/hcpt_decode.sv =====
module hcpt_decode
   import hcpt_pkg::*;
(
   input  logic [SENSOR_W-1:0] sensor_bits,
   input  logic [STATE_W-1:0]  home_state,
   input  logic [STATE_W-1:0]  phase_lead,
   output hcpt_decode_type     decode
);

   logic [STATE_W-1:0] state;
   logic signed [5:0]  sum;
   logic signed [5:0]  rem;
   logic [INDEX_W-1:0] idx;

   always_comb begin
      state = SENSOR_TO_STATE[sensor_bits];
      // The sum spans -5..16, so six signed bits hold it.
      sum = $signed({3'b000, state}) - $signed({3'b000, home_state})
            + $signed({{3{phase_lead[2]}}, phase_lead}) + 6'sd6;
      rem = rem6(sum);
      idx = rem[INDEX_W-1:0];
      decode.rotor_state = state;
      decode.drive_index = idx;
      decode.gate_lines  = GATE_PATTERN[idx] ^ HIGH_SIDE_MASK;
   end

endmodule

// ===== sv/hcpt_position.sv =====
module hcpt_position
   import hcpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [STATE_W-1:0]    rotor_state,
   output logic [POSITION_W-1:0] position_next
);

   logic [STATE_W-1:0]    prev_state_ff;
   logic [STATE_W-1:0]    prev_state_in;
   logic [POSITION_W-1:0] count_ff;
   logic [POSITION_W-1:0] count_in;
   logic signed [3:0]     step;
   logic signed [3:0]     delta;

   always_comb begin
      step = $signed({1'b0, rotor_state}) - $signed({1'b0, prev_state_ff});
      // A step of five either way is a wrap of one state the other way.
      if (step == 4'sd5) begin
         delta = -4'sd1;
      end else if (step == -4'sd5) begin
         delta = 4'sd1;
      end else begin
         delta = step;
      end
      position_next = count_ff + {{(POSITION_W-4){delta[3]}}, delta};
      prev_state_in = load ? rotor_state : prev_state_ff;
      count_in      = load ? position_next : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_state_ff <= '0;
         count_ff      <= '0;
      end else begin
         prev_state_ff <= prev_state_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ===== sv/hall_commutation_position_tracker_core.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tdata[2:0] sensor_bits
// rsp      out        rsp_tvalid/rsp_tready  rotor_state, drive_index, gate_lines, position
// csr      in         csr_we                 csr_index, csr_wdata
//
// One request is taken per cycle unless the input stage is held; each gives one response.
// The depth is set by the input register and the response register around one lookup and add.
// Reset is synchronous and active high; it empties both stages and restores the registers.
// A stalled response holds the input stage, and the request side stalls only when both are full.

module hall_commutation_position_tracker_core
   import hcpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [2:0] sensor_bits, [7:3] zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [2:0] rotor_state, [5:3] drive_index,
                                               // [11:6] gate_lines, [43:12] position,
                                               // [47:44] zero
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [SENSOR_W-1:0]   in_sensor_ff;
   logic [SENSOR_W-1:0]   in_sensor_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [RSP_DATA_W-1:0] out_data_in;
   logic [STATE_W-1:0]    home_state_ff;
   logic [STATE_W-1:0]    home_state_in;
   logic [STATE_W-1:0]    phase_lead_ff;
   logic [STATE_W-1:0]    phase_lead_in;
   logic                  advance;
   logic                  accept;
   hcpt_decode_type       decode;
   logic [POSITION_W-1:0] position_next;

   // The input stage moves on whenever the response register is free or being drained.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   hcpt_decode u_decode (
      .sensor_bits (in_sensor_ff),
      .home_state  (home_state_ff),
      .phase_lead  (phase_lead_ff),
      .decode      (decode)
   );

   // The position count and previous state update only as a request leaves the input stage.
   hcpt_position u_position (
      .clock         (clock),
      .reset         (reset),
      .load          (advance),
      .rotor_state   (decode.rotor_state),
      .position_next (position_next)
   );

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_sensor_in = accept ? req_tdata[SENSOR_W-1:0] : in_sensor_ff;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      out_data_in = advance ? {4'b0000, position_next, decode.gate_lines,
                               decode.drive_index, decode.rotor_state}
                            : out_data_ff;

      home_state_in = home_state_ff;
      phase_lead_in = phase_lead_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOME_STATE: home_state_in = csr_wdata;
            CSR_PHASE_LEAD: phase_lead_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         home_state_ff <= HOME_STATE_RESET;
         phase_lead_ff <= PHASE_LEAD_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         home_state_ff <= home_state_in;
         phase_lead_ff <= phase_lead_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_sensor_ff <= in_sensor_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   // The decode table never yields state six.
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6)
      else $error("rotor state six reached the response");

   // Drive indexes six and seven select the all-off pattern.
   a_off_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:3] == 3'd6 || rsp_tdata[5:3] == 3'd7)
      |-> rsp_tdata[11:6] == HIGH_SIDE_MASK)
      else $error("unused drive index did not switch all gates off");

   // A full input stage behind a stalled response must hold its request.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready
      |=> in_valid_ff && $stable(in_sensor_ff))
      else $error("input stage lost a request during a stall");

   // A held response changes only when a request moves into the register.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !advance |=> $stable(out_data_ff))
      else $error("response data changed without a request");
`endif

endmodule
